>>> rtl/core/lca_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the lca binary lifting engine
// no dependencies
package lca_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int LOG_LEVELS = 10;
    localparam int ID_W       = 10;
    localparam int LV_W       = 4;
    localparam int CNT_W      = 11;
    localparam int JADDR_W    = LV_W + ID_W;
    localparam int SUM_W      = 12;
    localparam int DEPTH_MAX  = 1023;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH,
        ST_BL_RD1, ST_BL_RD2, ST_BL_WR,
        ST_D_START, ST_D_TOP, ST_D_RD, ST_D_U, ST_D_CHK, ST_D_WR,
        ST_Q_DB, ST_Q_SW, ST_Q_LIFT, ST_Q_LA, ST_Q_EQ,
        ST_Q_R, ST_Q_RB, ST_Q_CMP, ST_Q_FIN, ST_Q_FA, ST_Q_DEP, ST_Q_DD,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_CAPTURE, DP_LOAD, DP_B_INIT,
        DP_BL_RD1, DP_BL_RD2, DP_BL_WR,
        DP_D_START, DP_D_TOP, DP_D_RD, DP_D_U, DP_D_CHK, DP_D_WR,
        DP_Q_DA, DP_Q_DB, DP_Q_SW, DP_Q_LIFT, DP_Q_LA, DP_Q_EQ,
        DP_Q_R, DP_Q_RB, DP_Q_CMP, DP_Q_FIN, DP_Q_FA, DP_Q_DEP, DP_Q_DD,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic op_build;
        logic op_query;
        logic q_oob;
        logic n_zero;
        logic j_last;
        logic lv_zero;
        logic lv_top;
        logic top;
        logic jrd_ne_u;
        logic diff_zero;
        logic diff_ge;
        logic ab_eq;
    } dp_stat_t;

endpackage

>>> rtl/core/lca_binary_lifting_engine_top.sv
`timescale 1ns / 1ps
// top level of the lca binary lifting engine
// depends on lca_pkg, lca_controller and lca_datapath
//
// One request is worked at a time; the next is taken once the result sits in
// the output register, even if it is still stalled. Timing is set by the
// single-port jump table, whose reads are registered. A load, an unused op
// code or an out of range query goes straight to the result. A query reads
// both depths, then walks the levels from the top down to the lowest set bit
// of the depth difference, lifting the deeper node at each set bit, then does
// the common lift of both nodes over all levels and the final reads of the
// parent and its depth; when one node is an ancestor of the other the common
// lift and two of the final reads are skipped. A build fills the jump levels
// for every active node, then runs the depth pass node by node.
// Tables are not cleared by reset: load every node before a build, and build
// before a query.
module lca_binary_lifting_engine_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [9:0]  node_a,
    input  logic [9:0]  node_b,
    input  logic        is_root,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  ancestor,
    output logic [9:0]  ancestor_depth,
    output logic        status
);
    import lca_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lca_controller u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lca_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .op             (op),
        .node_a         (node_a),
        .node_b         (node_b),
        .is_root        (is_root),
        .ancestor       (ancestor),
        .ancestor_depth (ancestor_depth),
        .status         (status)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted but engine not busy");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in progress");

    a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (ancestor == '0 && ancestor_depth == '0))
        else $error("error result carries nonzero fields");

endmodule

>>> rtl/core/lca_datapath.sv
`timescale 1ns / 1ps
// jump and depth memories, walk registers and result registers
// depends on lca_pkg
module lca_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lca_pkg::dp_cmd_t       cmd,
    output lca_pkg::dp_stat_t      stat,
    input  logic                   cfg_we,
    input  logic [10:0]            cfg_wdata,
    input  logic [1:0]             op,
    input  logic [9:0]             node_a,
    input  logic [9:0]             node_b,
    input  logic                   is_root,
    output logic [9:0]             ancestor,
    output logic [9:0]             ancestor_depth,
    output logic                   status
);
    import lca_pkg::*;

    logic [ID_W-1:0]    jump_mem [2**JADDR_W];
    logic [ID_W-1:0]    depth_mem [MAX_NODES];

    logic [CNT_W-1:0]   node_count_reg;
    logic [CNT_W-1:0]   n_act;
    logic [1:0]         op_reg;
    logic [ID_W-1:0]    a_reg, b_reg, v_reg, u_reg, j_reg, diff_reg;
    logic [ID_W-1:0]    da_reg, jrd_reg, drd_reg;
    logic               root_reg;
    logic [LV_W-1:0]    lv_reg;
    logic [SUM_W-1:0]   d_reg, d_inc;
    logic [ID_W-1:0]    res_anc_reg, res_dep_reg;
    logic               res_status_reg;
    logic [ID_W-1:0]    out_anc_reg, out_dep_reg;
    logic               out_status_reg;

    logic               a_oob, b_oob, load_oob;
    logic               jre, jwe, dre, dwe;
    logic [LV_W-1:0]    j_lv;
    logic [ID_W-1:0]    j_node, j_wdata, d_addr, d_wdata;

    assign n_act    = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                            : node_count_reg;
    assign a_oob    = {1'b0, a_reg} >= n_act;
    assign b_oob    = {1'b0, b_reg} >= n_act;
    assign load_oob = a_oob || (!root_reg && b_oob);
    assign d_inc    = d_reg + SUM_W'(1);

    assign stat.op_build  = (op_reg == OP_BUILD);
    assign stat.op_query  = (op_reg == OP_QUERY);
    assign stat.q_oob     = a_oob || b_oob;
    assign stat.n_zero    = (n_act == '0);
    assign stat.j_last    = (({1'b0, j_reg} + CNT_W'(1)) == n_act);
    assign stat.lv_zero   = (lv_reg == '0);
    assign stat.lv_top    = (lv_reg == LV_W'(LOG_LEVELS));
    assign stat.top       = (jrd_reg == v_reg);
    assign stat.jrd_ne_u  = (jrd_reg != u_reg);
    assign stat.diff_zero = (diff_reg == '0);
    assign stat.diff_ge   = ((diff_reg >> lv_reg) != '0);
    assign stat.ab_eq     = (a_reg == b_reg);

    // memory port control
    always_comb
    begin
        jre     = 1'b0;
        jwe     = 1'b0;
        j_lv    = lv_reg;
        j_node  = a_reg;
        j_wdata = jrd_reg;
        dre     = 1'b0;
        dwe     = 1'b0;
        d_addr  = a_reg;
        d_wdata = '0;
        unique case (cmd.op)
            DP_LOAD:
            begin
                jwe     = (op_reg == OP_LOAD) && !load_oob;
                j_lv    = '0;
                j_wdata = root_reg ? a_reg : b_reg;
            end
            DP_BL_RD1:
            begin
                jre    = 1'b1;
                j_lv   = lv_reg - LV_W'(1);
                j_node = j_reg;
            end
            DP_BL_RD2:
            begin
                jre    = 1'b1;
                j_lv   = lv_reg - LV_W'(1);
                j_node = jrd_reg;
            end
            DP_BL_WR:
            begin
                jwe    = 1'b1;
                j_node = j_reg;
            end
            DP_D_START:
            begin
                jre    = 1'b1;
                j_lv   = '0;
                j_node = j_reg;
            end
            DP_D_TOP:
            begin
                dwe    = stat.top;
                d_addr = j_reg;
            end
            DP_D_RD:
            begin
                jre    = 1'b1;
                j_node = v_reg;
            end
            DP_D_U:
            begin
                jre    = 1'b1;
                j_lv   = '0;
                j_node = jrd_reg;
            end
            DP_D_WR:
            begin
                dwe     = 1'b1;
                d_addr  = j_reg;
                d_wdata = (d_inc > SUM_W'(DEPTH_MAX)) ? ID_W'(DEPTH_MAX)
                                                      : d_inc[ID_W-1:0];
            end
            DP_Q_DA:
            begin
                dre = 1'b1;
            end
            DP_Q_DB:
            begin
                dre    = 1'b1;
                d_addr = b_reg;
            end
            DP_Q_LIFT:
            begin
                jre = !stat.diff_zero && stat.diff_ge;
            end
            DP_Q_R:
            begin
                jre = 1'b1;
            end
            DP_Q_RB:
            begin
                jre    = 1'b1;
                j_node = b_reg;
            end
            DP_Q_FIN:
            begin
                jre  = 1'b1;
                j_lv = '0;
            end
            DP_Q_DEP:
            begin
                dre    = 1'b1;
                d_addr = res_anc_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (jwe)
        begin
            jump_mem[{j_lv, j_node}] <= j_wdata;
        end
        if (jre)
        begin
            jrd_reg <= jump_mem[{j_lv, j_node}];
        end
        if (dwe)
        begin
            depth_mem[d_addr] <= d_wdata;
        end
        if (dre)
        begin
            drd_reg <= depth_mem[d_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(MAX_NODES);
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // walk and result registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_CAPTURE:
            begin
                op_reg   <= op;
                a_reg    <= node_a;
                b_reg    <= node_b;
                root_reg <= is_root;
            end
            DP_LOAD:
            begin
                res_anc_reg    <= '0;
                res_dep_reg    <= '0;
                res_status_reg <= ((op_reg == OP_LOAD) && load_oob)
                               || ((op_reg == OP_QUERY) && stat.q_oob);
            end
            DP_B_INIT:
            begin
                lv_reg         <= LV_W'(1);
                j_reg          <= '0;
                res_anc_reg    <= '0;
                res_dep_reg    <= '0;
                res_status_reg <= 1'b0;
            end
            DP_BL_WR:
            begin
                if (stat.j_last)
                begin
                    j_reg  <= '0;
                    lv_reg <= lv_reg + LV_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + ID_W'(1);
                end
            end
            DP_D_START:
            begin
                v_reg <= j_reg;
                d_reg <= '0;
            end
            DP_D_TOP:
            begin
                lv_reg <= LV_W'(LOG_LEVELS);
                if (stat.top)
                begin
                    j_reg <= j_reg + ID_W'(1);
                end
            end
            DP_D_U:
            begin
                u_reg <= jrd_reg;
            end
            DP_D_CHK:
            begin
                if (stat.jrd_ne_u)
                begin
                    v_reg <= u_reg;
                    d_reg <= d_reg + (SUM_W'(1) << lv_reg);
                end
                if (!stat.lv_zero)
                begin
                    lv_reg <= lv_reg - LV_W'(1);
                end
            end
            DP_D_WR:
            begin
                j_reg <= j_reg + ID_W'(1);
            end
            DP_Q_DB:
            begin
                da_reg <= drd_reg;
            end
            DP_Q_SW:
            begin
                lv_reg <= LV_W'(LOG_LEVELS);
                if (da_reg < drd_reg)
                begin
                    a_reg    <= b_reg;
                    b_reg    <= a_reg;
                    diff_reg <= drd_reg - da_reg;
                end
                else
                begin
                    diff_reg <= da_reg - drd_reg;
                end
            end
            DP_Q_LIFT:
            begin
                if (!stat.diff_zero)
                begin
                    if (stat.diff_ge)
                    begin
                        diff_reg <= diff_reg - (ID_W'(1) << lv_reg);
                    end
                    else
                    begin
                        lv_reg <= lv_reg - LV_W'(1);
                    end
                end
            end
            DP_Q_LA:
            begin
                a_reg <= jrd_reg;
                if (!stat.lv_zero)
                begin
                    lv_reg <= lv_reg - LV_W'(1);
                end
            end
            DP_Q_EQ:
            begin
                lv_reg      <= LV_W'(LOG_LEVELS);
                res_anc_reg <= a_reg;
            end
            DP_Q_RB:
            begin
                u_reg <= jrd_reg;
            end
            DP_Q_CMP:
            begin
                if (stat.jrd_ne_u)
                begin
                    a_reg <= u_reg;
                    b_reg <= jrd_reg;
                end
                if (!stat.lv_zero)
                begin
                    lv_reg <= lv_reg - LV_W'(1);
                end
            end
            DP_Q_FA:
            begin
                res_anc_reg <= jrd_reg;
            end
            DP_Q_DD:
            begin
                res_dep_reg    <= drd_reg;
                res_status_reg <= 1'b0;
            end
            DP_OUT:
            begin
                out_anc_reg    <= res_anc_reg;
                out_dep_reg    <= res_dep_reg;
                out_status_reg <= res_status_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign ancestor       = out_anc_reg;
    assign ancestor_depth = out_dep_reg;
    assign status         = out_status_reg;

endmodule

>>> rtl/core/lca_controller.sv
`timescale 1ns / 1ps
// sequencing state machine for load, build and query
// depends on lca_pkg
module lca_controller
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  lca_pkg::dp_stat_t      stat,
    output lca_pkg::dp_cmd_t       cmd
);
    import lca_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        out_valid_next = (out_valid_reg && out_stall);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.op_build)
                begin
                    cmd.op     = DP_B_INIT;
                    state_next = stat.n_zero ? ST_DONE : ST_BL_RD1;
                end
                else if (stat.op_query && !stat.q_oob)
                begin
                    cmd.op     = DP_Q_DA;
                    state_next = ST_Q_DB;
                end
                else
                begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_DONE;
                end
            end
            ST_BL_RD1:
            begin
                cmd.op     = DP_BL_RD1;
                state_next = ST_BL_RD2;
            end
            ST_BL_RD2:
            begin
                cmd.op     = DP_BL_RD2;
                state_next = ST_BL_WR;
            end
            ST_BL_WR:
            begin
                cmd.op     = DP_BL_WR;
                state_next = (stat.j_last && stat.lv_top) ? ST_D_START : ST_BL_RD1;
            end
            ST_D_START:
            begin
                cmd.op     = DP_D_START;
                state_next = ST_D_TOP;
            end
            ST_D_TOP:
            begin
                cmd.op = DP_D_TOP;
                if (stat.top)
                begin
                    state_next = stat.j_last ? ST_DONE : ST_D_START;
                end
                else
                begin
                    state_next = ST_D_RD;
                end
            end
            ST_D_RD:
            begin
                cmd.op     = DP_D_RD;
                state_next = ST_D_U;
            end
            ST_D_U:
            begin
                cmd.op     = DP_D_U;
                state_next = ST_D_CHK;
            end
            ST_D_CHK:
            begin
                cmd.op     = DP_D_CHK;
                state_next = stat.lv_zero ? ST_D_WR : ST_D_RD;
            end
            ST_D_WR:
            begin
                cmd.op     = DP_D_WR;
                state_next = stat.j_last ? ST_DONE : ST_D_START;
            end
            ST_Q_DB:
            begin
                cmd.op     = DP_Q_DB;
                state_next = ST_Q_SW;
            end
            ST_Q_SW:
            begin
                cmd.op     = DP_Q_SW;
                state_next = ST_Q_LIFT;
            end
            ST_Q_LIFT:
            begin
                cmd.op = DP_Q_LIFT;
                priority if (stat.diff_zero)
                begin
                    state_next = ST_Q_EQ;
                end
                else if (stat.diff_ge)
                begin
                    state_next = ST_Q_LA;
                end
                else
                begin
                    state_next = ST_Q_LIFT;
                end
            end
            ST_Q_LA:
            begin
                cmd.op     = DP_Q_LA;
                state_next = ST_Q_LIFT;
            end
            ST_Q_EQ:
            begin
                cmd.op     = DP_Q_EQ;
                state_next = stat.ab_eq ? ST_Q_DEP : ST_Q_R;
            end
            ST_Q_R:
            begin
                cmd.op     = DP_Q_R;
                state_next = ST_Q_RB;
            end
            ST_Q_RB:
            begin
                cmd.op     = DP_Q_RB;
                state_next = ST_Q_CMP;
            end
            ST_Q_CMP:
            begin
                cmd.op     = DP_Q_CMP;
                state_next = stat.lv_zero ? ST_Q_FIN : ST_Q_R;
            end
            ST_Q_FIN:
            begin
                cmd.op     = DP_Q_FIN;
                state_next = ST_Q_FA;
            end
            ST_Q_FA:
            begin
                cmd.op     = DP_Q_FA;
                state_next = ST_Q_DEP;
            end
            ST_Q_DEP:
            begin
                cmd.op     = DP_Q_DEP;
                state_next = ST_Q_DD;
            end
            ST_Q_DD:
            begin
                cmd.op     = DP_Q_DD;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.op         = DP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> verif/lca_binary_lifting_engine_top_test.sv
`timescale 1ns / 1ps
// self-checking bench for lca_binary_lifting_engine_top: loads trees, builds, runs queries
// ancestry is predicted from local jump and depth tables; depends on lca_pkg and the rtl
module lca_binary_lifting_engine_top_test;
    import lca_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int DOG_LIMIT   = 400000;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [9:0] anc;
        logic [9:0] dep;
        logic       st;
    } lca_answer_t;

    class lca_scoreboard;
        logic [9:0]  jump[MAX_NODES][LOG_LEVELS + 1];
        logic [9:0]  depth[MAX_NODES];
        logic [10:0] node_limit;
        lca_answer_t pending[$];
        int          mismatches;

        function void set_count(logic [10:0] v);
            node_limit = v;
        endfunction

        function int active();
            return (node_limit < MAX_NODES) ? int'(node_limit) : MAX_NODES;
        endfunction

        function bit at_top(logic [9:0] v);
            return jump[v][0] == v;
        endfunction

        function void rebuild();
            int n;
            int d;
            logic [9:0] v;
            logic [9:0] u;
            n = active();
            for (int lv = 1; lv <= LOG_LEVELS; lv++)
                for (int j = 0; j < n; j++)
                    jump[j][lv] = jump[jump[j][lv - 1]][lv - 1];
            for (int j = 0; j < n; j++)
            begin
                v = 10'(j);
                d = 0;
                if (!at_top(v))
                begin
                    for (int lv = LOG_LEVELS; lv >= 0; lv--)
                    begin
                        u = jump[v][lv];
                        if (!at_top(u))
                        begin
                            v = u;
                            d += 1 << lv;
                        end
                    end
                    d += 1;
                end
                depth[j] = (d > DEPTH_MAX) ? 10'(DEPTH_MAX) : 10'(d);
            end
        endfunction

        function logic [9:0] common_of(logic [9:0] a, logic [9:0] b);
            logic [9:0] t;
            int diff;
            if (depth[a] < depth[b])
            begin
                t = a;
                a = b;
                b = t;
            end
            diff = int'(depth[a]) - int'(depth[b]);
            for (int lv = LOG_LEVELS; lv >= 0; lv--)
                if ((1 << lv) <= diff)
                begin
                    diff -= 1 << lv;
                    a = jump[a][lv];
                end
            if (a == b)
                return a;
            for (int lv = LOG_LEVELS; lv >= 0; lv--)
                if (jump[a][lv] != jump[b][lv])
                begin
                    t = jump[a][lv];
                    b = jump[b][lv];
                    a = t;
                end
            return jump[a][0];
        endfunction

        function void note(logic [1:0] code, logic [9:0] a, logic [9:0] b, logic root);
            lca_answer_t r;
            int n;
            n = active();
            r = '0;
            if (code == OP_LOAD)
            begin
                if (a >= n || (!root && b >= n))
                    r.st = 1'b1;
                else
                    jump[a][0] = root ? a : b;
            end
            else if (code == OP_BUILD)
                rebuild();
            else if (code == OP_QUERY)
            begin
                if (a >= n || b >= n)
                    r.st = 1'b1;
                else
                begin
                    r.anc = common_of(a, b);
                    r.dep = depth[r.anc];
                end
            end
            pending = {pending, r};
        endfunction

        function void check(lca_answer_t got);
            lca_answer_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result anc=%0d dep=%0d st=%0d",
                             got.anc, got.dep, got.st);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected anc=%0d dep=%0d st=%0d, ",
                              "got anc=%0d dep=%0d st=%0d"},
                             want.anc, want.dep, want.st, got.anc, got.dep, got.st);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = '0;
    logic [9:0]  node_a = '0;
    logic [9:0]  node_b = '0;
    logic        is_root = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [9:0]  ancestor;
    logic [9:0]  ancestor_depth;
    logic        status;

    lca_scoreboard sb = new();
    bit idle_on = 1'b1;
    bit hold_go = 1'b0;
    int quiet = 0;

    always #2 clk = ~clk;

    lca_binary_lifting_engine_top i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .node_a         (node_a),
        .node_b         (node_b),
        .is_root        (is_root),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ancestor       (ancestor),
        .ancestor_depth (ancestor_depth),
        .status         (status)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note(op, node_a, node_b, is_root);
            if (out_valid && !out_stall)
                sb.check({ancestor, ancestor_depth, status});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet > DOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver side stall
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_go = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_request(logic [1:0] code, logic [9:0] a, logic [9:0] b, logic root);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        node_a   <= a;
        node_b   <= b;
        is_root  <= root;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_nodes(logic [10:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        sb.set_count(v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random forest over 0..n-1, mostly parents below the child
    task automatic load_tree(int n);
        for (int j = 0; j < n; j++)
        begin
            if (j == 0 || $urandom_range(0, 19) == 0)
                send_request(OP_LOAD, 10'(j), 10'($urandom), 1'b1);
            else
                send_request(OP_LOAD, 10'(j), 10'($urandom_range(0, j - 1)), 1'b0);
        end
    endtask

    task automatic random_mix(int n, int count);
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_request(OP_QUERY, 10'($urandom_range(0, n - 1)),
                             10'($urandom_range(0, n - 1)), 1'($urandom));
            else if (pick < 75)
                send_request(OP_QUERY, 10'($urandom), 10'($urandom), 1'($urandom));
            else if (pick < 88)
                send_request(OP_LOAD, 10'($urandom_range(0, n - 1)),
                             ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                         : 10'($urandom_range(0, n - 1)),
                             ($urandom_range(0, 7) == 0));
            else if (pick < 94)
                send_request(OP_BUILD, 10'($urandom), 10'($urandom), 1'($urandom));
            else
                send_request(OP_SPARE, 10'($urandom), 10'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        sb.set_count(11'd1024);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single node tree
        set_nodes(11'd1);
        send_request(OP_LOAD, 10'd0, 10'd1023, 1'b1);
        send_request(OP_BUILD, 10'd0, 10'd0, 1'b0);
        send_request(OP_QUERY, 10'd0, 10'd0, 1'b0);
        send_request(OP_QUERY, 10'd0, 10'd1, 1'b0);
        send_request(OP_LOAD, 10'd1, 10'd0, 1'b0);

        // small chain with a second tree, out of range ids and unused op
        set_nodes(11'd6);
        send_request(OP_LOAD, 10'd0, 10'd0, 1'b1);
        send_request(OP_LOAD, 10'd1, 10'd0, 1'b0);
        send_request(OP_LOAD, 10'd2, 10'd1, 1'b0);
        send_request(OP_LOAD, 10'd3, 10'd1, 1'b0);
        send_request(OP_LOAD, 10'd4, 10'd4, 1'b1);
        send_request(OP_LOAD, 10'd5, 10'd4, 1'b0);
        send_request(OP_LOAD, 10'd1023, 10'd0, 1'b0);
        send_request(OP_LOAD, 10'd2, 10'd1023, 1'b0);
        send_request(OP_SPARE, 10'd1023, 10'd1023, 1'b1);
        send_request(OP_BUILD, 10'd1023, 10'd1023, 1'b1);
        send_request(OP_QUERY, 10'd2, 10'd3, 1'b0);
        send_request(OP_QUERY, 10'd2, 10'd0, 1'b0);
        send_request(OP_QUERY, 10'd5, 10'd3, 1'b0);
        send_request(OP_QUERY, 10'd6, 10'd0, 1'b0);
        send_request(OP_QUERY, 10'd0, 10'd1023, 1'b0);
        // cycle with no root
        send_request(OP_LOAD, 10'd4, 10'd5, 1'b0);
        send_request(OP_BUILD, 10'd0, 10'd0, 1'b0);
        send_request(OP_QUERY, 10'd5, 10'd4, 1'b0);
        send_request(OP_QUERY, 10'd2, 10'd5, 1'b0);

        set_nodes(11'd40);
        load_tree(40);
        send_request(OP_BUILD, 10'd0, 10'd0, 1'b0);
        random_mix(40, 40);
        hold_go = 1'b1;
        random_mix(40, 30);
        drain();
        random_mix(40, 40);

        set_nodes(11'd12);
        load_tree(12);
        send_request(OP_BUILD, 10'd0, 10'd0, 1'b0);
        random_mix(12, 60);

        set_nodes(11'd96);
        load_tree(96);
        send_request(OP_BUILD, 10'd0, 10'd0, 1'b0);
        random_mix(96, 60);

        // large tree, no idling from here on
        idle_on = 1'b0;
        set_nodes(11'd560);
        load_tree(560);
        send_request(OP_BUILD, 10'd0, 10'd0, 1'b0);
        random_mix(560, 40);

        // count above the node limit, queries on the built nodes only
        set_nodes(11'd2047);
        for (int k = 0; k < 40; k++)
            send_request(OP_QUERY, 10'($urandom_range(0, 559)),
                         10'($urandom_range(0, 559)), 1'b0);

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
